@@ rtl/mcarng_pkg.sv @@
// Shared types and constants for the multistate cellular-automaton word generator.
// No dependencies; imported by mcarng_ring and the top-level core.
package mcarng_pkg;

    localparam int NUM_CELLS_DEF    = 51;
    localparam int NUM_STATES_DEF   = 10;
    localparam int WINDOW_CELLS_DEF = 12;

    // Word length of the emitted value; the port is fixed at 32 bits.
    localparam int          WORD_BITS = 32;
    localparam int          OUT_W     = 32;
    localparam logic [OUT_W-1:0] WORD_MASK =
        (WORD_BITS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'((64'd1 << WORD_BITS) - 64'd1);

    localparam int REQ_W   = 2;
    localparam int POS_W   = 10;
    localparam int VALUE_W = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_RULE = 2'd0,
        REQ_SEED = 2'd1,
        REQ_STEP = 2'd2
    } mcarng_req_t;

    // Controls from the sequencer to the cell ring.
    typedef struct packed {
        logic seed_we;  // load one seed cell
        logic shift;    // rotate ring by one place
        logic first;    // cell 0 is at the head
        logic last;     // cell NUM_CELLS-1 is at the head
        logic put;      // new digit from the rule memory is available
    } mcarng_ring_ctrl_t;

endpackage

@@ rtl/mcarng_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcarng_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mcarng_ring.sv @@
// Cell ring: rotating shift line of digits with fixed taps at the head.
// Depends on mcarng_pkg (ring control struct).
module mcarng_ring
    import mcarng_pkg::*;
#(
    parameter int NUM_CELLS = NUM_CELLS_DEF,
    parameter int DIGIT_W   = 4,
    localparam int IDX_W    = $clog2(NUM_CELLS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mcarng_ring_ctrl_t ctrl,
    input  logic [IDX_W-1:0]  seed_idx,
    input  logic [DIGIT_W-1:0] seed_digit,
    input  logic [DIGIT_W-1:0] new_digit,
    output logic [DIGIT_W-1:0] left_digit,
    output logic [DIGIT_W-1:0] self_digit,
    output logic [DIGIT_W-1:0] right_digit
);

    logic [DIGIT_W-1:0] cells_reg  [NUM_CELLS];
    logic [DIGIT_W-1:0] cells_next [NUM_CELLS];
    logic [DIGIT_W-1:0] prev_old_reg;   // old value of the cell just processed
    logic [DIGIT_W-1:0] first_old_reg;  // old value of cell 0

    // Head is the cell being updated; the new digit of the previous cell
    // lands one place short of the tail, as it has moved on once since.
    always_comb
    begin
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            cells_next[k] = cells_reg[k];
        end
        if (ctrl.shift)
        begin
            for (int k = 0; k < NUM_CELLS - 1; k++)
            begin
                cells_next[k] = cells_reg[k+1];
            end
            cells_next[NUM_CELLS-1] = cells_reg[0];
            if (ctrl.put)
            begin
                cells_next[NUM_CELLS-2] = new_digit;
            end
        end
        else if (ctrl.put)
        begin
            cells_next[NUM_CELLS-1] = new_digit;
        end
        else if (ctrl.seed_we)
        begin
            cells_next[seed_idx] = seed_digit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CELLS; k++)
            begin
                cells_reg[k] <= '0;
            end
        end
        else
        begin
            cells_reg <= cells_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            prev_old_reg <= cells_reg[0];
            if (ctrl.first)
            begin
                first_old_reg <= cells_reg[0];
            end
        end
    end

    assign self_digit  = cells_reg[0];
    assign left_digit  = ctrl.first ? cells_reg[NUM_CELLS-1] : prev_old_reg;
    assign right_digit = ctrl.last  ? first_old_reg : cells_reg[1];

endmodule

@@ rtl/multistate_ca_random_generator_core.sv @@
// Top level of the multistate cellular-automaton word generator: sequencer,
// rule lookup and window accumulation. Depends on mcarng_pkg, mcarng_ram, mcarng_ring.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, req_type,        | request
//          | position, value                      |
//  out     | out_valid, out_stall, random_word    | result
//
// Rule and seed loads can follow each other every cycle while no step is in progress.
// A step: the transfer, one rule read per cell as the ring rotates once, a drain state for
// the last read data, a publish state to hand the word over. Window digits accumulate as
// they come out.
// A step does not finish while a previous word is still stalled at the output.
// Reset clears the cells to zero; the rule table holds nothing until loaded.
module multistate_ca_random_generator_core
    import mcarng_pkg::*;
#(
    parameter int NUM_CELLS    = NUM_CELLS_DEF,
    parameter int NUM_STATES   = NUM_STATES_DEF,
    parameter int WINDOW_CELLS = WINDOW_CELLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [POS_W-1:0]   position,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [OUT_W-1:0]   random_word
);

    localparam int RULE_DEPTH = NUM_STATES * NUM_STATES * NUM_STATES;
    localparam int RA_W       = $clog2(RULE_DEPTH);
    localparam int DIGIT_W    = $clog2(NUM_STATES);
    localparam int IDX_W      = $clog2(NUM_CELLS);
    localparam int EXT_W      = (RA_W > POS_W) ? RA_W : POS_W;
    localparam int WIN_START  = NUM_CELLS / 2 - WINDOW_CELLS / 2;
    localparam int WIN_END    = WIN_START + WINDOW_CELLS - 1;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_UPDATE  = 4'b0010,
        ST_DRAIN   = 4'b0100,
        ST_PUBLISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [OUT_W-1:0]  acc_reg, acc_next;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  word_reg;

    logic              in_fire;
    logic              out_free;
    logic              digit_ok;
    logic [EXT_W-1:0]  pos_ext;
    logic              rule_we;
    mcarng_ring_ctrl_t ring_ctrl;
    logic [DIGIT_W-1:0] left_digit, self_digit, right_digit;
    logic [DIGIT_W-1:0] rule_rdata;
    logic [RA_W-1:0]   rule_raddr;
    logic              in_window;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign digit_ok = (32'(value) < NUM_STATES);
    assign pos_ext  = EXT_W'(position);
    assign rule_we  = in_fire && (req_type == REQ_RULE) && digit_ok
                      && (32'(position) < RULE_DEPTH);

    always_comb
    begin
        ring_ctrl.seed_we = in_fire && (req_type == REQ_SEED) && digit_ok
                            && (32'(position) < NUM_CELLS);
        ring_ctrl.shift   = (state_reg == ST_UPDATE);
        ring_ctrl.first   = (cnt_reg == '0);
        ring_ctrl.last    = (cnt_reg == IDX_W'(NUM_CELLS - 1));
        ring_ctrl.put     = ((state_reg == ST_UPDATE) && (cnt_reg != '0))
                            || (state_reg == ST_DRAIN);
    end

    mcarng_ring #(
        .NUM_CELLS (NUM_CELLS),
        .DIGIT_W   (DIGIT_W)
    ) u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ring_ctrl),
        .seed_idx    (pos_ext[IDX_W-1:0]),
        .seed_digit  (value[DIGIT_W-1:0]),
        .new_digit   (rule_rdata),
        .left_digit  (left_digit),
        .self_digit  (self_digit),
        .right_digit (right_digit)
    );

    // Rule index = (left*d + self)*d + right; digits are always below d.
    assign rule_raddr = (RA_W'(left_digit) * RA_W'(NUM_STATES) + RA_W'(self_digit))
                        * RA_W'(NUM_STATES) + RA_W'(right_digit);

    mcarng_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (RULE_DEPTH)
    ) u_rule_ram (
        .clk   (clk),
        .we    (rule_we),
        .waddr (pos_ext[RA_W-1:0]),
        .wdata (value[DIGIT_W-1:0]),
        .raddr (rule_raddr),
        .rdata (rule_rdata)
    );

    assign in_window = (rd_idx_reg >= IDX_W'(WIN_START)) && (rd_idx_reg <= IDX_W'(WIN_END));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        if (ring_ctrl.put && in_window)
        begin
            acc_next = acc_reg * OUT_W'(NUM_STATES) + OUT_W'(rule_rdata);
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req_type == REQ_STEP))
                begin
                    state_next = ST_UPDATE;
                    cnt_next   = '0;
                    acc_next   = '0;
                end
            end
            ST_UPDATE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (ring_ctrl.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == ST_PUBLISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == ST_UPDATE)
        begin
            rd_idx_reg <= cnt_reg;
        end
        if ((state_reg == ST_PUBLISH) && out_free)
        begin
            word_reg <= acc_reg & WORD_MASK;
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;

    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (req_type == REQ_STEP)) |=> (state_reg == ST_UPDATE) && (cnt_reg == '0))
        else $error("step transfer did not start a ring pass at cell 0");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> ($past(state_reg) == ST_UPDATE)
                                    && ($past(cnt_reg) == IDX_W'(NUM_CELLS - 1)))
        else $error("drain entered before the whole ring was read");

    a_word_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_PUBLISH))
        else $error("result raised outside publish");

    a_rule_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rule_we || ring_ctrl.seed_we) |-> (state_reg == ST_IDLE) && !ring_ctrl.shift)
        else $error("load written during a ring pass");

endmodule
